[design/cgpr_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cgpr_pkg
// Constants and types shared by the call graph profile recorder.
// ----------------------------------------------------------------------------
package cgpr_pkg;

	// Sizing of the node table and the call stack.
	localparam int MAX_NODES      = 256;
	localparam int STACK_DEPTH    = 16;
	localparam int WORDS_PER_NODE = 16;

	localparam int NODE_W  = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
	localparam int NCNT_W  = $clog2(MAX_NODES + 1);
	localparam int SIDX_W  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int SP_W    = $clog2(STACK_DEPTH + 1);
	localparam int OFF_W   = $clog2(WORDS_PER_NODE);

	// Field widths of the stream payloads.
	localparam int WORD_W     = 32;
	localparam int IN_FIELDS  = 8;
	localparam int IN_WORDS   = 2 * IN_FIELDS;
	localparam int IN_W       = IN_WORDS * WORD_W;
	localparam int ADDR_W     = 12;
	localparam int OUT_DATA_W = 48;
	localparam int OUT_USER_W = 3;

	// Result counts per kind of input item.
	localparam int ENTRY_WRITES = 2;
	localparam int EXIT_WRITES  = 14;
	localparam int EXIT_OFFSET  = 2;

	typedef enum logic [1:0] {
		STATUS_OK        = 2'd0,
		STATUS_OVERFLOW  = 2'd1,
		STATUS_UNDERFLOW = 2'd2,
		STATUS_FULL      = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_LOOKUP = 3'b010,
		ST_EMIT   = 3'b100
	} state_t;

	typedef enum logic [1:0] {
		KIND_ENTRY = 2'd0,
		KIND_EXIT  = 2'd1,
		KIND_ERROR = 2'd2
	} kind_t;

	// One call stack entry: node index and level word of an open call.
	typedef struct packed {
		logic [NODE_W-1:0] node;
		logic [WORD_W-1:0] level;
	} stack_entry_t;

endpackage
`default_nettype wire

[design/call_graph_profile_recorder.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// call_graph_profile_recorder
// Turns function entry and exit events into word writes to a node table.
// ----------------------------------------------------------------------------
// Usage:
// The slave stream (s_*) takes one event per transfer. A nonzero low word of
// node_word marks a function entry, zero marks an exit. The master stream
// (m_*) gives one word write, or one error result, per transfer; m_tlast
// marks the final result caused by an event.
// An entry gives two writes (ID word and level word) into a fresh node
// record and pushes the node on the call stack. An exit pops the stack and
// gives fourteen writes: the cycle count and six event counters, low word
// first. Overflow, underflow or a full table gives one result with no write.
// Timing: an event is taken in ST_IDLE, where the stack top is read into a
// register; ST_LOOKUP makes the decisions, and ST_EMIT then sends one result
// per cycle while the receiver does not stall. The block holds one event at
// a time, as s_tready is high only in ST_IDLE.
// When the receiver stalls, the result register holds and the block waits;
// s_tready is low until the last result of the event is in the register.
// Reset empties the call stack and restarts node allocation at node 0; the
// stack memory itself is not cleared, as entries are read only after a push.
module call_graph_profile_recorder
	import cgpr_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	// Fields from bit 0 up: node_word, cycle_count, event_zero, event_one,
	// event_two, event_three, event_four, event_five (64 bits each).
	input  wire logic [IN_W-1:0]       s_tdata,
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	// Fields from bit 0 up: word_address (12), word_data (32), zero fill (4).
	output logic [OUT_DATA_W-1:0]      m_tdata,
	// Fields from bit 0 up: write_enable (1), status (2).
	output logic [OUT_USER_W-1:0]      m_tuser,
	// last_of_run.
	output logic                       m_tlast
);

	// Control state.
	state_t              state_q;
	kind_t               kind_q;
	logic [SP_W-1:0]     sp_q;
	logic [NCNT_W-1:0]   next_node_q;
	logic [OFF_W-1:0]    cnt_q;
	logic [OFF_W-1:0]    last_cnt_q;

	// Captured event and per-event working values.
	logic [IN_WORDS-1:0][WORD_W-1:0] in_q;
	logic [NODE_W-1:0]   node_q;
	logic [WORD_W-1:0]   level_q;
	status_t             status_q;

	// Call stack memory with a registered read port.
	stack_entry_t        stack_mem [STACK_DEPTH];
	stack_entry_t        rd_q;
	logic [SIDX_W-1:0]   rd_idx;
	logic                push;

	// Result register.
	logic                m_tvalid_q;
	logic [ADDR_W-1:0]   addr_q;
	logic [WORD_W-1:0]   data_q;
	logic                we_q;
	status_t             out_status_q;
	logic                last_q;

	logic                accept;
	logic                slot_free;
	logic                is_entry;
	logic                overflow;
	logic                underflow;
	logic                table_full;
	logic [WORD_W-1:0]   new_level;
	logic [OFF_W-1:0]    word_idx;

	assign s_tready  = (state_q == ST_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign slot_free = !m_tvalid_q || m_tready;

	// The stack top lies one below the stack pointer.
	assign rd_idx = SIDX_W'(sp_q - 1'b1);

	always_ff @(posedge clk) begin
		if (accept) begin
			rd_q <= stack_mem[rd_idx];
		end
		if (push) begin
			stack_mem[sp_q[SIDX_W-1:0]] <= '{node: NODE_W'(next_node_q), level: new_level};
		end
	end

	// Decisions made once the stack top has been read.
	assign is_entry   = (in_q[0] != '0);
	assign overflow   = (sp_q >= SP_W'(STACK_DEPTH));
	assign table_full = (next_node_q >= NCNT_W'(MAX_NODES));
	assign underflow  = (sp_q == '0);
	assign new_level  = (sp_q != '0) ? (rd_q.level + 32'd1) : (in_q[1] | 32'h1);
	assign push       = (state_q == ST_LOOKUP) && is_entry && !overflow && !table_full;

	// Exit words sit in the event at the same 32-bit position as their offset.
	assign word_idx = (kind_q == KIND_EXIT) ? OFF_W'(cnt_q + OFF_W'(EXIT_OFFSET)) : cnt_q;

	always_ff @(posedge clk) begin
		if (accept) begin
			in_q <= s_tdata;
		end
		if (state_q == ST_LOOKUP) begin
			level_q <= new_level;
			if (is_entry) begin
				node_q <= NODE_W'(next_node_q);
			end else begin
				node_q <= rd_q.node;
			end
			priority if (is_entry && overflow) begin
				status_q <= STATUS_OVERFLOW;
			end else if (is_entry && table_full) begin
				status_q <= STATUS_FULL;
			end else if (!is_entry && underflow) begin
				status_q <= STATUS_UNDERFLOW;
			end else begin
				status_q <= STATUS_OK;
			end
		end
		if (state_q == ST_EMIT && slot_free) begin
			if (kind_q == KIND_ERROR) begin
				addr_q <= '0;
				data_q <= '0;
				we_q   <= 1'b0;
			end else begin
				addr_q <= ADDR_W'({node_q, word_idx});
				we_q   <= 1'b1;
				if (kind_q == KIND_ENTRY && cnt_q != '0) begin
					data_q <= level_q;
				end else begin
					data_q <= in_q[word_idx];
				end
			end
			out_status_q <= status_q;
			last_q       <= (cnt_q == last_cnt_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			kind_q      <= KIND_ERROR;
			sp_q        <= '0;
			next_node_q <= '0;
			cnt_q       <= '0;
			last_cnt_q  <= '0;
			m_tvalid_q  <= 1'b0;
		end else begin
			if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_LOOKUP;
					end
				end
				ST_LOOKUP: begin
					cnt_q   <= '0;
					state_q <= ST_EMIT;
					if (is_entry) begin
						if (overflow || table_full) begin
							kind_q     <= KIND_ERROR;
							last_cnt_q <= '0;
						end else begin
							kind_q      <= KIND_ENTRY;
							last_cnt_q  <= OFF_W'(ENTRY_WRITES - 1);
							sp_q        <= SP_W'(sp_q + 1'b1);
							next_node_q <= NCNT_W'(next_node_q + 1'b1);
						end
					end else begin
						if (underflow) begin
							kind_q     <= KIND_ERROR;
							last_cnt_q <= '0;
						end else begin
							kind_q     <= KIND_EXIT;
							last_cnt_q <= OFF_W'(EXIT_WRITES - 1);
							sp_q       <= SP_W'(sp_q - 1'b1);
						end
					end
				end
				ST_EMIT: begin
					if (slot_free) begin
						m_tvalid_q <= 1'b1;
						cnt_q      <= OFF_W'(cnt_q + 1'b1);
						if (cnt_q == last_cnt_q) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{(OUT_DATA_W - ADDR_W - WORD_W){1'b0}}, data_q, addr_q};
	assign m_tuser  = {out_status_q, we_q};
	assign m_tlast  = last_q;

endmodule
`default_nettype wire
